// ----- hw/rtl/rrsdf_pkg.sv -----
package rrsdf_pkg;

  // Pixel coordinate and fixed-point fraction sizes.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;

  // Geometry in Q(COORD).(FRAC); threshold in Q8.(FRAC) signed.
  localparam int GEO_W  = COORD_BITS + FRAC_BITS;
  localparam int TH_W   = 9 + FRAC_BITS;
  localparam int AX_W   = GEO_W + 4;          // signed per-axis offsets at double scale
  localparam int M_W    = AX_W - 1;           // clamped (non-negative) axis offsets
  localparam int SQ_W   = 2 * M_W + 1;        // sum of two squares
  localparam int RAD_W  = SQ_W + 1;           // square root working registers
  localparam int ROOT_W = (SQ_W + 1) / 2;     // square root result
  localparam int T2_W   = AX_W + 3;           // smoothstep argument before clamp
  localparam int T_W    = FRAC_BITS + 1;      // clamped smoothstep input, 0..ONE
  localparam int TT_W   = 2 * FRAC_BITS + 1;
  localparam int W3_W   = FRAC_BITS + 2;
  localparam int S_W    = 3 * FRAC_BITS + 1;
  localparam int CV_W   = S_W + 8;

  localparam int ONE_F  = 1 << FRAC_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int RGB_W      = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOLID_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_RGB       = 3'd7;

  localparam logic [TH_W-1:0] TH_RESET = TH_W'(ONE_F / 2);

  // Pipeline depth: input, offset, fold, clamp, square, sum, root steps,
  // smoothstep clamp, t*t, cubic, output.
  localparam int NST = 10 + ROOT_W;

endpackage

// ----- hw/rtl/rounded_rect_sdf_coverage.sv -----
// Rounded-rectangle coverage generator, one pixel per beat.
//
// Input channel (in_valid/in_ready): integer pixel position plus row and
// frame end marks. Output channel (out_valid/out_ready): fill color and an
// 8-bit coverage alpha from the signed distance to a rounded box, shaped by
// a one-pixel smoothstep centered on edge_threshold. Solid mode gives
// opaque white. The end marks come out unchanged with their pixel.
//
// Config port: cfg_we/cfg_index/cfg_wdata, to be written only while the pipe is
// empty; the block does not enforce this. Derived geometry is registered.
//
// Throughput: one beat per cycle while out_ready does not stall the pipe.
// The pipeline depth is set mostly by the square root, which resolves one
// root bit per pipeline stage.
//
// Reset (rst_n low, synchronous) empties the pipe and loads register
// defaults. A stall on out_ready freezes every stage in place; in_ready
// is low only while the output register holds an untaken beat.
module rounded_rect_sdf_coverage (
  input  logic                            clk,
  input  logic                            rst_n,
  // config
  input  logic                            cfg_we,
  input  logic [rrsdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrsdf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // pixel in
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rrsdf_pkg::COORD_BITS-1:0] in_pixel_x,
  input  logic [rrsdf_pkg::COORD_BITS-1:0] in_pixel_y,
  input  logic                            in_end_of_row,
  input  logic                            in_end_of_frame,
  // result out
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_coverage,
  output logic                            out_row_done,
  output logic                            out_frame_done
);
  import rrsdf_pkg::*;

  // ---------------- configuration registers ----------------
  logic                    solid_r;
  logic signed [GEO_W:0]   left_r, top_r;
  logic [GEO_W-1:0]        width_r, height_r;
  logic [GEO_W-2:0]        radius_r;
  logic signed [TH_W-1:0]  thresh_r;
  logic [RGB_W-1:0]        fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solid_r  <= 1'b0;
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      radius_r <= '0;
      thresh_r <= TH_RESET;
      fill_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOLID_MODE:     solid_r  <= cfg_wdata[0];
        CFG_RECT_LEFT:      left_r   <= cfg_wdata[GEO_W:0];
        CFG_RECT_TOP:       top_r    <= cfg_wdata[GEO_W:0];
        CFG_RECT_WIDTH:     width_r  <= cfg_wdata[GEO_W-1:0];
        CFG_RECT_HEIGHT:    height_r <= cfg_wdata[GEO_W-1:0];
        CFG_CORNER_RADIUS:  radius_r <= cfg_wdata[GEO_W-2:0];
        CFG_EDGE_THRESHOLD: thresh_r <= cfg_wdata[TH_W-1:0];
        CFG_FILL_RGB:       fill_r   <= cfg_wdata[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- derived geometry (static between writes) ----------------
  // All geometry is at double scale so half sizes stay exact.
  // cx = 2*left + width, rmw = r2 - width, kofs = r2 + 2*threshold - ONE.
  logic [GEO_W-1:0]       r2_r, r2_nxt, rad2;
  logic signed [AX_W-1:0] cx_r, cy_r, rmwx_r, rmwy_r;
  logic signed [T2_W-1:0] kofs_r;

  always_comb begin
    rad2   = {radius_r, 1'b0};
    r2_nxt = rad2;
    if (r2_nxt > width_r)  r2_nxt = width_r;
    if (r2_nxt > height_r) r2_nxt = height_r;
  end

  always_ff @(posedge clk) begin
    r2_r   <= r2_nxt;
    cx_r   <= $signed({{(AX_W-GEO_W-2){left_r[GEO_W]}}, left_r, 1'b0})
            + $signed({{(AX_W-GEO_W){1'b0}}, width_r});
    cy_r   <= $signed({{(AX_W-GEO_W-2){top_r[GEO_W]}}, top_r, 1'b0})
            + $signed({{(AX_W-GEO_W){1'b0}}, height_r});
    rmwx_r <= $signed({{(AX_W-GEO_W){1'b0}}, r2_r})
            - $signed({{(AX_W-GEO_W){1'b0}}, width_r});
    rmwy_r <= $signed({{(AX_W-GEO_W){1'b0}}, r2_r})
            - $signed({{(AX_W-GEO_W){1'b0}}, height_r});
    kofs_r <= $signed({{(T2_W-GEO_W){1'b0}}, r2_r})
            + $signed({{(T2_W-TH_W-1){thresh_r[TH_W-1]}}, thresh_r, 1'b0})
            - $signed(T2_W'(ONE_F));
  end

  // ---------------- pipeline control ----------------
  // Single stall enable: every stage moves when the output slot is free
  // or being taken this cycle.
  logic           adv;
  logic [NST-1:0] vld_r;
  logic [1:0]     flag_r [NST];

  assign adv      = !vld_r[NST-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flag_r[0] <= {in_end_of_frame, in_end_of_row};
      for (int i = 1; i < NST; i++) flag_r[i] <= flag_r[i-1];
    end
  end

  // ---------------- stage data ----------------
  logic [COORD_BITS-1:0]  px_r, py_r;          // stage 1
  logic signed [AX_W-1:0] dx_r, dy_r;          // stage 2: P - C
  logic signed [AX_W-1:0] qx_r, qy_r;          // stage 3: |P - C| - size + r2
  logic [M_W-1:0]         mx_r, my_r;          // stage 4: max(q, 0)
  logic signed [AX_W-1:0] inner_r;             // stage 4: min(max(qx, qy), 0)
  logic [SQ_W-1:0]        sqx_r, sqy_r;        // stage 5
  logic signed [T2_W-1:0] off5_r;              // stage 5: inner - kofs
  logic [RAD_W-1:0]       sn_r  [ROOT_W+1];    // root remainder per step
  logic [RAD_W-1:0]       sr_r  [ROOT_W+1];    // root partial per step
  logic signed [T2_W-1:0] off_r [ROOT_W+1];
  logic [T_W-1:0]         t_r;
  logic [TT_W-1:0]        tt_r;
  logic [W3_W-1:0]        w3_r;
  logic [S_W-1:0]         s_r;
  logic [7:0]             red_r, green_r, blue_r, cov_r;
  logic                   row_r, frame_r;

  // combinational next values
  logic signed [AX_W-1:0] px2, py2, dxa, dya, qmax;
  logic [RAD_W-1:0]       sn_nxt [ROOT_W];
  logic [RAD_W-1:0]       sr_nxt [ROOT_W];
  logic [RAD_W-1:0]       trial  [ROOT_W];
  logic signed [T2_W-1:0] t2, t2h;
  logic [T_W-1:0]         t_nxt;
  logic [S_W-1:0]         inv_s;
  logic [CV_W-1:0]        cov_full;

  always_comb begin
    // Sample position at double scale: pixel << (FRAC_BITS + 1).
    px2 = $signed({{(AX_W-GEO_W-1){1'b0}}, px_r, {(FRAC_BITS+1){1'b0}}});
    py2 = $signed({{(AX_W-GEO_W-1){1'b0}}, py_r, {(FRAC_BITS+1){1'b0}}});
    dxa = dx_r[AX_W-1] ? -dx_r : dx_r;
    dya = dy_r[AX_W-1] ? -dy_r : dy_r;
    qmax = (qx_r > qy_r) ? qx_r : qy_r;

    // Restoring square root, one result bit per stage.
    for (int k = 0; k < ROOT_W; k++) begin
      trial[k] = sr_r[k] + (RAD_W'(1) << (2 * (ROOT_W - 1 - k)));
      if (sn_r[k] >= trial[k]) begin
        sn_nxt[k] = sn_r[k] - trial[k];
        sr_nxt[k] = (sr_r[k] >> 1) + (RAD_W'(1) << (2 * (ROOT_W - 1 - k)));
      end else begin
        sn_nxt[k] = sn_r[k];
        sr_nxt[k] = sr_r[k] >> 1;
      end
    end

    // t2 = D - 2*threshold + ONE; t = clamp(t2 / 2, 0, ONE).
    t2  = $signed({{(T2_W-ROOT_W){1'b0}}, sr_r[ROOT_W][ROOT_W-1:0]}) + off_r[ROOT_W];
    t2h = t2 >>> 1;
    if (t2 <= 0)
      t_nxt = '0;
    else if (t2h > $signed(T2_W'(ONE_F)))
      t_nxt = T_W'(ONE_F);
    else
      t_nxt = t2h[T_W-1:0];

    // coverage = ((ONE^3 - s) * 255) >> 3F, with *255 as shift-subtract.
    inv_s    = (S_W'(1) << (3 * FRAC_BITS)) - s_r;
    cov_full = ({{(CV_W-S_W){1'b0}}, inv_s} << 8) - {{(CV_W-S_W){1'b0}}, inv_s};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;

      dx_r <= px2 - cx_r;
      dy_r <= py2 - cy_r;

      qx_r <= dxa + rmwx_r;
      qy_r <= dya + rmwy_r;

      mx_r    <= qx_r[AX_W-1] ? '0 : qx_r[M_W-1:0];
      my_r    <= qy_r[AX_W-1] ? '0 : qy_r[M_W-1:0];
      inner_r <= qmax[AX_W-1] ? qmax : '0;

      sqx_r  <= SQ_W'(mx_r * mx_r);
      sqy_r  <= SQ_W'(my_r * my_r);
      off5_r <= $signed({{(T2_W-AX_W){inner_r[AX_W-1]}}, inner_r}) - kofs_r;

      sn_r[0]  <= {1'b0, sqx_r} + {1'b0, sqy_r};
      sr_r[0]  <= '0;
      off_r[0] <= off5_r;
      for (int k = 0; k < ROOT_W; k++) begin
        sn_r[k+1]  <= sn_nxt[k];
        sr_r[k+1]  <= sr_nxt[k];
        off_r[k+1] <= off_r[k];
      end

      t_r <= t_nxt;

      tt_r <= TT_W'(t_r * t_r);
      w3_r <= W3_W'(3 * ONE_F) - {t_r, 1'b0};

      s_r <= S_W'(tt_r * w3_r);

      if (solid_r) begin
        red_r   <= 8'hFF;
        green_r <= 8'hFF;
        blue_r  <= 8'hFF;
        cov_r   <= 8'hFF;
      end else begin
        red_r   <= fill_r[23:16];
        green_r <= fill_r[15:8];
        blue_r  <= fill_r[7:0];
        cov_r   <= cov_full[3*FRAC_BITS+7:3*FRAC_BITS];
      end
      row_r   <= flag_r[NST-2][0];
      frame_r <= flag_r[NST-2][1];
    end
  end

  assign out_valid      = vld_r[NST-1];
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_coverage   = cov_r;
  assign out_row_done   = row_r;
  assign out_frame_done = frame_r;

endmodule

// ----- tb/tb.sv -----
module tb;
  import rrsdf_pkg::*;

  // One pixel beat on the input side.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  eor;
    logic                  eof;
  } pixel_t;

  // One shaded beat on the output side, in port order.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] coverage;
    logic       row_done;
    logic       frame_done;
  } shade_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] in_pixel_x = '0;
  logic [COORD_BITS-1:0] in_pixel_y = '0;
  logic                  in_end_of_row = 1'b0;
  logic                  in_end_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [7:0]            out_coverage;
  logic                  out_row_done;
  logic                  out_frame_done;

  // Shadow copy of the shape registers, same widths as the block keeps them.
  logic                   solid_q;
  logic signed [GEO_W:0]  left_q;
  logic signed [GEO_W:0]  top_q;
  logic [GEO_W-1:0]       width_q;
  logic [GEO_W-1:0]       height_q;
  logic [GEO_W-2:0]       radius_q;
  logic signed [TH_W-1:0] thresh_q;
  logic [RGB_W-1:0]       fill_q;

  pixel_t pixel_q[$];      // pixels waiting for the driver
  shade_t shade_q[$];      // predicted shades, oldest first
  int     pixels_queued = 0;
  int     shades_seen = 0; // NBA-updated, read by the stimulus loop
  int     errors = 0;
  int     in_pct = 0;      // chance (percent) that a pixel is preceded by idle cycles
  int     out_pct = 0;     // same for stalls on out_ready
  int     in_gap = 0;
  int     out_hold = 0;

  rounded_rect_sdf_coverage i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the pipe hangs.
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int draw_wait(int pct);
    if ($urandom_range(0, 99) < pct)
      return int'($urandom_range(0, 19));
    return 0;
  endfunction

  // Floor square root, bit-pair method.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n)
      bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Doubled offset of one axis from the radius-shrunk inner box.
  function automatic longint box_axis(logic [COORD_BITS-1:0] pix, longint lo, longint size,
                                      longint r2);
    longint d;
    d = (longint'(pix) <<< (FRAC_BITS + 1)) - (2 * lo + size);
    if (d < 0)
      d = -d;
    return d - size + r2;
  endfunction

  // Expected shade of one pixel under the current shadow registers.
  function automatic shade_t shade_pixel(pixel_t p);
    shade_t res;
    longint r2, qx, qy, mx, my, inner_d, dist2, t2, t, s, cov;
    res.row_done   = p.eor;
    res.frame_done = p.eof;
    if (solid_q) begin
      res.red      = 8'hFF;
      res.green    = 8'hFF;
      res.blue     = 8'hFF;
      res.coverage = 8'hFF;
    end else begin
      // radius saturates at half the shorter side (all values doubled)
      r2 = 2 * longint'(radius_q);
      if (r2 > longint'(width_q))
        r2 = longint'(width_q);
      if (r2 > longint'(height_q))
        r2 = longint'(height_q);
      qx = box_axis(p.x, longint'(left_q), longint'(width_q), r2);
      qy = box_axis(p.y, longint'(top_q), longint'(height_q), r2);
      mx = (qx > 0) ? qx : 0;
      my = (qy > 0) ? qy : 0;
      inner_d = (qx > qy) ? qx : qy;
      if (inner_d > 0)
        inner_d = 0;
      dist2 = floor_sqrt(mx * mx + my * my);
      dist2 = dist2 + inner_d - r2;
      // smoothstep one pixel wide, centered on the threshold
      t2 = dist2 - 2 * longint'(thresh_q) + ONE_F;
      t = (t2 <= 0) ? 0 : (t2 >>> 1);
      if (t > ONE_F)
        t = ONE_F;
      s = t * t * (3 * ONE_F - 2 * t);
      cov = (((longint'(1) <<< (3 * FRAC_BITS)) - s) * 255) >>> (3 * FRAC_BITS);
      res.coverage = cov[7:0];
      res.red      = fill_q[23:16];
      res.green    = fill_q[15:8];
      res.blue     = fill_q[7:0];
    end
    return res;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Driver: one pixel per beat, random idle cycles between pixels.
  // The expected shade is worked out on the accepting edge, so it always
  // sees the register values the block used.
  always @(posedge clk) begin : pixel_drive
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready)
        shade_q.push_back(shade_pixel({in_pixel_x, in_pixel_y, in_end_of_row,
                                       in_end_of_frame}));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pixel_q.size() != 0) begin
          nxt = pixel_q.pop_front();
          in_pixel_x      <= nxt.x;
          in_pixel_y      <= nxt.y;
          in_end_of_row   <= nxt.eor;
          in_end_of_frame <= nxt.eof;
          in_valid        <= 1'b1;
          in_gap          <= draw_wait(in_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output beat against the oldest prediction and
  // stalls out_ready for a random count after each beat.
  always @(posedge clk) begin : shade_check
    shade_t want;
    shade_t got;
    int     n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else begin
      n = out_hold;
      if (out_valid && out_ready) begin
        got = {out_red, out_green, out_blue, out_coverage, out_row_done, out_frame_done};
        if (shade_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = shade_q.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("coverage", want.coverage, got.coverage);
          check_field("row_done", want.row_done, got.row_done);
          check_field("frame_done", want.frame_done, got.frame_done);
        end
        shades_seen <= shades_seen + 1;
        n = draw_wait(out_pct);
      end
      if (n != 0) begin
        out_ready <= 1'b0;
        out_hold  <= n - 1;
      end else begin
        out_ready <= 1'b1;
        out_hold  <= 0;
      end
    end
  end

  task automatic send_pixel(int x, int y, bit eor, bit eof);
    pixel_q.push_back({x[COORD_BITS-1:0], y[COORD_BITS-1:0], eor, eof});
    pixels_queued++;
  endtask

  // Wait until every queued pixel has come back out.
  task automatic drain();
    while (shades_seen != pixels_queued)
      @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    // bits above each register's width are dropped
    case (idx)
      CFG_SOLID_MODE:     solid_q  = data[0];
      CFG_RECT_LEFT:      left_q   = data[GEO_W:0];
      CFG_RECT_TOP:       top_q    = data[GEO_W:0];
      CFG_RECT_WIDTH:     width_q  = data[GEO_W-1:0];
      CFG_RECT_HEIGHT:    height_q = data[GEO_W-1:0];
      CFG_CORNER_RADIUS:  radius_q = data[GEO_W-2:0];
      CFG_EDGE_THRESHOLD: thresh_q = data[TH_W-1:0];
      CFG_FILL_RGB:       fill_q   = data[RGB_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the write enable, then wait for the derived geometry to settle.
  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  initial begin : stimulus
    int lx, ly, px, py;
    bit wild;
    solid_q  = 1'b0;
    left_q   = '0;
    top_q    = '0;
    width_q  = '0;
    height_q = '0;
    radius_q = '0;
    thresh_q = TH_RESET;
    fill_q   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: zero-size shape, coverage follows distance alone.
    // Coordinate extremes and every flag combination.
    send_pixel(0, 0, 1'b0, 1'b0);
    send_pixel(4095, 4095, 1'b1, 1'b1);
    send_pixel(0, 4095, 1'b1, 1'b0);
    send_pixel(4095, 0, 1'b0, 1'b1);
    drain();

    // 20x12 box at (10.5, 8), radius 3; junk above solid_mode's bit.
    set_reg(CFG_SOLID_MODE, 24'hFFFFFE);
    set_reg(CFG_RECT_LEFT, 24'd2688);
    set_reg(CFG_RECT_TOP, 24'd2048);
    set_reg(CFG_RECT_WIDTH, 24'd5120);
    set_reg(CFG_RECT_HEIGHT, 24'd3072);
    set_reg(CFG_CORNER_RADIUS, 24'd768);
    set_reg(CFG_EDGE_THRESHOLD, 24'd128);
    set_reg(CFG_FILL_RGB, 24'h123456);
    cfg_done();
    send_pixel(20, 14, 1'b0, 1'b0);   // deep inside
    send_pixel(10, 14, 1'b0, 1'b0);   // half a pixel off the left edge
    send_pixel(11, 14, 1'b0, 1'b0);
    send_pixel(9, 14, 1'b1, 1'b0);
    send_pixel(10, 8, 1'b0, 1'b0);    // rounded corner
    send_pixel(11, 9, 1'b0, 1'b0);
    send_pixel(30, 20, 1'b0, 1'b0);
    send_pixel(31, 21, 1'b1, 1'b0);
    send_pixel(0, 0, 1'b0, 0);
    send_pixel(4095, 4095, 1'b1, 1'b1);
    drain();

    // Radius far beyond half the shorter side: must saturate.
    set_reg(CFG_CORNER_RADIUS, 24'hFFFFFF);
    set_reg(CFG_RECT_WIDTH, 24'd4096);
    set_reg(CFG_RECT_HEIGHT, 24'd10240);
    set_reg(CFG_EDGE_THRESHOLD, 24'd0);
    cfg_done();
    send_pixel(18, 30, 1'b0, 1'b0);
    send_pixel(10, 10, 1'b0, 1'b0);
    send_pixel(26, 30, 1'b0, 1'b0);
    send_pixel(18, 8, 1'b1, 1'b0);
    drain();

    // Solid mode: opaque white whatever the geometry.
    set_reg(CFG_SOLID_MODE, 24'd1);
    cfg_done();
    send_pixel(0, 0, 1'b0, 1'b0);
    send_pixel(15, 12, 1'b1, 1'b1);
    drain();

    // Register extremes, with junk above the register widths.
    set_reg(CFG_SOLID_MODE, 24'd0);
    set_reg(CFG_RECT_LEFT, 24'hF00000);
    set_reg(CFG_RECT_TOP, 24'h0FFFFF);
    set_reg(CFG_RECT_WIDTH, 24'hFFFFFF);
    set_reg(CFG_RECT_HEIGHT, 24'hF00000);
    set_reg(CFG_CORNER_RADIUS, 24'd0);
    set_reg(CFG_EDGE_THRESHOLD, 24'h010000);
    set_reg(CFG_FILL_RGB, 24'hFFFFFF);
    cfg_done();
    send_pixel(0, 0, 1'b0, 1'b0);
    send_pixel(4095, 4095, 1'b1, 1'b0);
    send_pixel(2048, 0, 1'b0, 1'b1);
    drain();
    set_reg(CFG_EDGE_THRESHOLD, 24'h00FFFF);
    cfg_done();
    send_pixel(0, 4095, 1'b0, 1'b0);
    send_pixel(4095, 0, 1'b1, 1'b1);
    drain();

    // Random part: each phase picks a shape, then pixels mostly scattered over
    // its box and an 8-pixel margin so the antialias ramp is hit; some phases
    // load raw 24-bit values into every register.
    for (int ph = 0; ph < 10; ph++) begin
      wild = ($urandom_range(0, 3) == 0);
      in_pct  = (ph == 0) ? 0 : 45 * int'($urandom_range(0, 2));
      out_pct = (ph == 0) ? 0 : 45 * int'($urandom_range(0, 2));
      if (wild) begin
        for (int r = 0; r < 8; r++)
          set_reg(r[CFG_IDX_W-1:0], 24'($urandom()));
      end else begin
        set_reg(CFG_SOLID_MODE, 24'($urandom_range(0, 9) == 0));
        set_reg(CFG_RECT_LEFT, 24'(int'($urandom_range(0, 3000 * 256)) - 16 * 256));
        set_reg(CFG_RECT_TOP, 24'(int'($urandom_range(0, 3000 * 256)) - 16 * 256));
        // mostly ordinary boxes, now and then a sliver
        set_reg(CFG_RECT_WIDTH, 24'($urandom_range(0, ($urandom_range(0, 4) == 0) ?
                                                       512 : 96 * 256)));
        set_reg(CFG_RECT_HEIGHT, 24'($urandom_range(0, ($urandom_range(0, 4) == 0) ?
                                                        512 : 96 * 256)));
        set_reg(CFG_CORNER_RADIUS, 24'($urandom_range(0, 48 * 256)));
        set_reg(CFG_EDGE_THRESHOLD, 24'(int'($urandom_range(0, 2048)) - 1024));
        set_reg(CFG_FILL_RGB, 24'($urandom()));
      end
      cfg_done();
      lx = int'(left_q >>> FRAC_BITS);
      ly = int'(top_q >>> FRAC_BITS);
      for (int k = 0; k < 53; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          px = int'($urandom_range(0, 4095));
          py = int'($urandom_range(0, 4095));
        end else begin
          px = lx + int'($urandom_range(0, width_q / 256 + 16)) - 8;
          py = ly + int'($urandom_range(0, height_q / 256 + 16)) - 8;
        end
        send_pixel(px, py, $urandom_range(0, 7) == 0, $urandom_range(0, 31) == 0);
      end
      drain();
    end

    // Let the pipe run dry and catch any stray beat.
    repeat (NST + 16) @(posedge clk);
    if (shade_q.size() != 0) begin
      $display("%0t: missing beats, expected %0d more, actual 0", $time, shade_q.size());
      errors++;
    end
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
